// File: rtl/dswd_pkg.sv
package dswd_pkg;

    // Field and register widths
    localparam int SAMPLE_W   = 10;
    localparam int ELAPSED_W  = 6;
    localparam int THR_W      = 10;
    localparam int DELAY_W    = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int SUM_OUT_W  = 14;
    localparam int DARK_W     = 20;
    localparam int MEAN_W     = 10;
    localparam int SAMPLE_MAX = 1023;

    // Queue between front and back, and the most items the block can hold
    localparam int QDEPTH       = 2;
    localparam int MAX_INFLIGHT = QDEPTH + 2;
    localparam int INFLIGHT_W   = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UP_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_DELAY    = 2'd2;

    // Register reset values
    localparam logic [THR_W-1:0]   UP_THRESHOLD_RST   = 10'd200;
    localparam logic [THR_W-1:0]   DOWN_THRESHOLD_RST = 10'd150;
    localparam logic [DELAY_W-1:0] SLEEP_DELAY_RST    = 16'd10;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  sample;
        logic [ELAPSED_W-1:0] elapsed;
        logic                 closes;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    typedef struct packed {
        logic [THR_W-1:0]   up_threshold;
        logic [THR_W-1:0]   down_threshold;
        logic [DELAY_W-1:0] sleep_delay;
    } cfg_t;

endpackage

// File: rtl/dswd_front.sv
module dswd_front import dswd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [SAMPLE_W-1:0]  light_sample,
    input  logic [ELAPSED_W-1:0] seconds_elapsed,
    output queue_head_t          head,
    input  logic                 pop
);

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    item_t             slot_reg [QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    item_t             new_item;

    // Stall while the queue is full
    assign in_stall = (count_reg == CNT_W'(QDEPTH));
    assign push     = in_valid && !in_stall;

    // Classify: a nonzero elapsed time closes the current second
    always_comb
    begin
        new_item.sample  = light_sample;
        new_item.elapsed = seconds_elapsed;
        new_item.closes  = (seconds_elapsed != '0);
    end

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold transferred items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = slot_reg[rd_ptr_reg];

endmodule

// File: rtl/dswd_div.sv
module dswd_div
#(
    parameter int W  = 18,
    parameter int QW = 10
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [W-1:0]  dividend,
    input  logic [W-1:0]  divisor,
    output logic          done,
    output logic [QW-1:0] quotient
);

    localparam int STEP_W = $clog2(QW);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [W-1:0]      rem_reg;
    logic [W-1:0]      dsr_reg;
    logic [QW-1:0]     quot_reg;
    logic              fits;

    // Restoring division, one quotient bit a cycle, most significant first
    assign fits = (rem_reg >= dsr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(QW - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift divisor down and collect quotient bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dividend;
            dsr_reg  <= divisor << (QW - 1);
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsr_reg;
            end
            dsr_reg  <= dsr_reg >> 1;
            quot_reg <= {quot_reg[QW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// File: rtl/dswd_back.sv
module dswd_back import dswd_pkg::*;
#(
    parameter int WINDOW                 = 16,
    parameter int MAX_SAMPLES_PER_SECOND = 255
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  queue_head_t          head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 get_up,
    output logic                 go_to_sleep,
    output logic [SUM_OUT_W-1:0] window_sum,
    output logic                 second_closed
);

    localparam int POS_W = $clog2(WINDOW);
    localparam int SUM_W = $clog2(WINDOW * SAMPLE_MAX + 1);
    localparam int ACC_W = $clog2(MAX_SAMPLES_PER_SECOND * SAMPLE_MAX + 1);
    localparam int CNT_W = $clog2(MAX_SAMPLES_PER_SECOND + 1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DIVIDE  = 3'd1;
    localparam logic [2:0] ST_UPDATE  = 3'd2;
    localparam logic [2:0] ST_COMPARE = 3'd3;
    localparam logic [2:0] ST_EMIT    = 3'd4;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    item_t                item_reg;
    item_t                item_next;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     sum_next;
    logic [MEAN_W-1:0]    mean_reg;
    logic [MEAN_W-1:0]    mean_next;
    logic [DARK_W-1:0]    dark_reg;
    logic [DARK_W-1:0]    dark_next;
    logic                 get_up_reg;
    logic                 get_up_next;
    logic                 sleep_reg;
    logic                 sleep_next;
    logic [ACC_W-1:0]     acc_reg;
    logic [ACC_W-1:0]     acc_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_get_up_reg;
    logic                 out_get_up_next;
    logic                 out_sleep_reg;
    logic                 out_sleep_next;
    logic [SUM_OUT_W-1:0] out_sum_reg;
    logic [SUM_OUT_W-1:0] out_sum_next;
    logic                 out_closed_reg;
    logic                 out_closed_next;

    logic [MEAN_W-1:0]    ring_mem [WINDOW];
    logic [MEAN_W-1:0]    rd_data_reg;
    logic [WINDOW-1:0]    ring_valid_reg;
    logic                 ring_we;
    logic [MEAN_W-1:0]    old_mean;

    logic                 div_start;
    logic                 div_done;
    logic [MEAN_W-1:0]    div_quot;

    logic [SUM_W-1:0]     up_scaled;
    logic [SUM_W-1:0]     down_scaled;
    logic                 sun_up;
    logic                 sun_down;
    logic [DARK_W:0]      dark_sum;
    logic [DARK_W-1:0]    dark_new;
    logic                 out_free;

    // Per-second mean
    dswd_div #(
        .W  (ACC_W),
        .QW (MEAN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (ACC_W'(cnt_reg)),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Ring of means: registered read at the current position
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[pos_reg] <= mean_reg;
        end
        rd_data_reg <= ring_mem[pos_reg];
    end

    // Entries never written read as darkness
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_valid_reg <= '0;
        end
        else if (ring_we)
        begin
            ring_valid_reg[pos_reg] <= 1'b1;
        end
    end

    assign old_mean = ring_valid_reg[pos_reg] ? rd_data_reg : '0;

    // Threshold compare against the window sum
    assign up_scaled   = SUM_W'(cfg.up_threshold) * SUM_W'(WINDOW);
    assign down_scaled = SUM_W'(cfg.down_threshold) * SUM_W'(WINDOW);
    assign sun_up      = (sum_reg > up_scaled);
    assign sun_down    = (sum_reg <= down_scaled);

    // Saturating dark time
    assign dark_sum = {1'b0, dark_reg} + (DARK_W + 1)'(item_reg.elapsed);
    always_comb
    begin
        if (!sun_down)
        begin
            dark_new = '0;
        end
        else if (dark_sum[DARK_W])
        begin
            dark_new = '1;
        end
        else
        begin
            dark_new = dark_sum[DARK_W-1:0];
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        pos_next        = pos_reg;
        sum_next        = sum_reg;
        mean_next       = mean_reg;
        dark_next       = dark_reg;
        get_up_next     = get_up_reg;
        sleep_next      = sleep_reg;
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_get_up_next = out_get_up_reg;
        out_sleep_next  = out_sleep_reg;
        out_sum_next    = out_sum_reg;
        out_closed_next = out_closed_reg;
        pop             = 1'b0;
        div_start       = 1'b0;
        ring_we         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop       = 1'b1;
                    item_next = head.item;
                    if (head.item.closes)
                    begin
                        div_start  = 1'b1;
                        pos_next   = (pos_reg == POS_W'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;
                        state_next = ST_DIVIDE;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    mean_next  = (cnt_reg == '0) ? '0 : div_quot;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                ring_we    = 1'b1;
                sum_next   = sum_reg - SUM_W'(old_mean) + SUM_W'(mean_reg);
                state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                get_up_next = sun_up;
                dark_next   = dark_new;
                sleep_next  = sun_down && (dark_new > DARK_W'(cfg.sleep_delay));
                acc_next    = '0;
                cnt_next    = '0;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_get_up_next = get_up_reg;
                    out_sleep_next  = sleep_reg;
                    out_sum_next    = SUM_OUT_W'(sum_reg);
                    out_closed_next = item_reg.closes;
                    if (cnt_reg < CNT_W'(MAX_SAMPLES_PER_SECOND))
                    begin
                        acc_next = acc_reg + ACC_W'(item_reg.sample);
                        cnt_next = cnt_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            sum_reg       <= '0;
            dark_reg      <= '0;
            get_up_reg    <= 1'b0;
            sleep_reg     <= 1'b0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            dark_reg      <= dark_next;
            get_up_reg    <= get_up_next;
            sleep_reg     <= sleep_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold item and result payload
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        mean_reg       <= mean_next;
        out_get_up_reg <= out_get_up_next;
        out_sleep_reg  <= out_sleep_next;
        out_sum_reg    <= out_sum_next;
        out_closed_reg <= out_closed_next;
    end

    assign out_valid     = out_valid_reg;
    assign get_up        = out_get_up_reg;
    assign go_to_sleep   = out_sleep_reg;
    assign window_sum    = out_sum_reg;
    assign second_closed = out_closed_reg;

endmodule

// File: rtl/daylight_sleep_wake_detector.sv
// Daylight sleep/wake detector. Each transfer on the input carries a light
// sample and the seconds elapsed since the last one; a nonzero count closes
// the current second, whose integer mean enters a WINDOW-deep ring, and the
// window sum is checked against up_threshold*WINDOW and down_threshold*WINDOW
// to set get_up and, after more than sleep_delay dark seconds, go_to_sleep.
// Exactly one result follows each input, in order. In the back end an item
// that closes a second goes through divide, update and compare before emit,
// the restoring divider forming the mean one quotient bit a cycle. A
// two-entry queue lets inputs keep arriving while the back end works, and the
// result register lets the next item start while a result waits. The block
// must be configured through cfg_we/cfg_index/cfg_data only while it is idle,
// which the block does not enforce; writes past the last index are ignored.
module daylight_sleep_wake_detector import dswd_pkg::*;
#(
    parameter int WINDOW                 = 16,
    parameter int MAX_SAMPLES_PER_SECOND = 255
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [SAMPLE_W-1:0]  light_sample,
    input  logic [ELAPSED_W-1:0] seconds_elapsed,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 get_up,
    output logic                 go_to_sleep,
    output logic [SUM_OUT_W-1:0] window_sum,
    output logic                 second_closed
);

    cfg_t        cfg_reg;
    queue_head_t head;
    logic        pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.up_threshold   <= UP_THRESHOLD_RST;
            cfg_reg.down_threshold <= DOWN_THRESHOLD_RST;
            cfg_reg.sleep_delay    <= SLEEP_DELAY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_UP_THRESHOLD:   cfg_reg.up_threshold   <= cfg_data[THR_W-1:0];
                REG_DOWN_THRESHOLD: cfg_reg.down_threshold <= cfg_data[THR_W-1:0];
                REG_SLEEP_DELAY:    cfg_reg.sleep_delay    <= cfg_data[DELAY_W-1:0];
                default:            ;
            endcase
        end
    end

    // Accept and classify
    dswd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .light_sample    (light_sample),
        .seconds_elapsed (seconds_elapsed),
        .head            (head),
        .pop             (pop)
    );

    // Close seconds, track the window and drive results
    dswd_back #(
        .WINDOW                 (WINDOW),
        .MAX_SAMPLES_PER_SECOND (MAX_SAMPLES_PER_SECOND)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .get_up        (get_up),
        .go_to_sleep   (go_to_sleep),
        .window_sum    (window_sum),
        .second_closed (second_closed)
    );

endmodule

// File: rtl/dswd_checker.sv
module dswd_checker import dswd_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic                 get_up,
    input logic                 go_to_sleep,
    input logic [SUM_OUT_W-1:0] window_sum,
    input logic                 second_closed
);

    logic                  in_xfer;
    logic                  out_xfer;
    logic [INFLIGHT_W-1:0] inflight_reg;
    logic                  prev_get_up_reg;
    logic                  prev_sleep_reg;
    logic [SUM_OUT_W-1:0]  prev_sum_reg;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    // Track items in flight and the last result transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg    <= '0;
            prev_get_up_reg <= 1'b0;
            prev_sleep_reg  <= 1'b0;
            prev_sum_reg    <= '0;
        end
        else
        begin
            case ({in_xfer, out_xfer})
                2'b10:   inflight_reg <= inflight_reg + 1'b1;
                2'b01:   inflight_reg <= inflight_reg - 1'b1;
                default: inflight_reg <= inflight_reg;
            endcase
            if (out_xfer)
            begin
                prev_get_up_reg <= get_up;
                prev_sleep_reg  <= go_to_sleep;
                prev_sum_reg    <= window_sum;
            end
        end
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable({get_up, go_to_sleep, window_sum, second_closed}))
        else $error("stalled result changed");

    // A result that closes no second repeats the previous flags and sum
    a_no_close_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !second_closed |->
            get_up == prev_get_up_reg && go_to_sleep == prev_sleep_reg &&
            window_sum == prev_sum_reg)
        else $error("flags changed without a closed second");

    // No result without an item behind it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> inflight_reg != '0)
        else $error("result transferred with no item in flight");

    // Queue, back end and result register bound the items held
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= INFLIGHT_W'(MAX_INFLIGHT))
        else $error("too many items in flight");

endmodule

bind daylight_sleep_wake_detector dswd_checker u_dswd_checker (.*);

// File: sim/tb_daylight_sleep_wake_detector.sv
`timescale 1ns / 100ps

module tb_daylight_sleep_wake_detector;
    import dswd_pkg::*;

    localparam int WINDOW         = 16;
    localparam int MAX_PER_SECOND = 255;
    localparam int RING_W         = $clog2(WINDOW);
    localparam int DARK_MAX       = (1 << DARK_W) - 1;
    localparam int QUIET_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int REPORT_LIMIT   = 10;

    // Index past the last register: writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic                 get_up;
        logic                 go_to_sleep;
        logic [SUM_OUT_W-1:0] window_sum;
        logic                 second_closed;
    } daylight_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [SAMPLE_W-1:0]  light_sample;
    logic [ELAPSED_W-1:0] seconds_elapsed;
    logic                 out_valid;
    logic                 out_stall;
    logic                 get_up;
    logic                 go_to_sleep;
    logic [SUM_OUT_W-1:0] window_sum;
    logic                 second_closed;

    // Predicted detector state and register copies
    logic [THR_W-1:0]     up_thr;
    logic [THR_W-1:0]     down_thr;
    logic [DELAY_W-1:0]   delay_cfg;
    logic [17:0]          bin_sum;
    logic [7:0]           bin_count;
    logic [MEAN_W-1:0]    mean_ring [WINDOW];
    logic [RING_W-1:0]    ring_pos;
    logic [SUM_OUT_W-1:0] window_total;
    logic [DARK_W-1:0]    dark_secs;
    logic                 get_up_state;
    logic                 sleep_state;

    daylight_result_t     expected_results [$];

    int unsigned          mismatches;
    int unsigned          transfers_in;
    int unsigned          results_seen;
    int unsigned          seconds_closed;
    int unsigned          get_up_high;
    int unsigned          sleep_high;
    int unsigned          settings_applied;
    int unsigned          quiet_cycles;
    int unsigned          stall_left;
    logic                 idle_on;

    daylight_sleep_wake_detector #(
        .WINDOW                 (WINDOW),
        .MAX_SAMPLES_PER_SECOND (MAX_PER_SECOND)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .light_sample    (light_sample),
        .seconds_elapsed (seconds_elapsed),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .get_up          (get_up),
        .go_to_sleep     (go_to_sleep),
        .window_sum      (window_sum),
        .second_closed   (second_closed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned gap_len();
        int unsigned roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void reset_detector_state();
        up_thr       = UP_THRESHOLD_RST;
        down_thr     = DOWN_THRESHOLD_RST;
        delay_cfg    = SLEEP_DELAY_RST;
        bin_sum      = '0;
        bin_count    = '0;
        for (int i = 0; i < WINDOW; i++)
            mean_ring[i] = '0;
        ring_pos     = '0;
        window_total = '0;
        dark_secs    = '0;
        get_up_state = 1'b0;
        sleep_state  = 1'b0;
    endfunction

    // Advance the detector by one sample and queue the flags it should report
    function automatic void advance_daylight(input logic [SAMPLE_W-1:0] sample,
                                             input logic [ELAPSED_W-1:0] elapsed);
        logic [MEAN_W-1:0] bin_mean;
        int unsigned       dark_next;
        logic              sun_up;
        logic              sun_down;
        daylight_result_t  res;
        bin_mean = '0;
        res.second_closed = (elapsed != 0);
        if (elapsed != 0)
        begin
            // close the current second: its mean replaces the next ring entry
            if (bin_count != 0)
                bin_mean = MEAN_W'(bin_sum / 18'(bin_count));
            ring_pos = RING_W'((32'(ring_pos) + 1) % WINDOW);
            window_total = window_total - SUM_OUT_W'(mean_ring[ring_pos])
                           + SUM_OUT_W'(bin_mean);
            mean_ring[ring_pos] = bin_mean;
            sun_up   = 32'(window_total) > 32'(up_thr) * WINDOW;
            sun_down = 32'(window_total) <= 32'(down_thr) * WINDOW;
            if (sun_down)
            begin
                dark_next = 32'(dark_secs) + 32'(elapsed);
                if (dark_next > DARK_MAX)
                    dark_next = DARK_MAX;
                dark_secs = DARK_W'(dark_next);
            end
            else
                dark_secs = '0;
            get_up_state = sun_up;
            sleep_state  = sun_down && (dark_secs > DARK_W'(delay_cfg));
            bin_sum      = '0;
            bin_count    = '0;
        end
        // a full second ignores further samples
        if (32'(bin_count) < MAX_PER_SECOND)
        begin
            bin_sum   = bin_sum + 18'(sample);
            bin_count = bin_count + 8'd1;
        end
        res.get_up      = get_up_state;
        res.go_to_sleep = sleep_state;
        res.window_sum  = window_total;
        expected_results.push_back(res);
    endfunction

    function automatic void log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%s", msg);
    endfunction

    function automatic void check_field(input string field,
                                        input logic [SUM_OUT_W-1:0] want,
                                        input logic [SUM_OUT_W-1:0] got);
        if (want !== got)
            log_mismatch($sformatf("result %0d %s: expected %0d, got %0d",
                                   results_seen, field, want, got));
    endfunction

    // Offer one sample and hold it until the transfer completes
    task automatic send_item(input logic [SAMPLE_W-1:0] sample,
                             input logic [ELAPSED_W-1:0] elapsed);
        int unsigned gap;
        gap = idle_on ? gap_len() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        light_sample    <= sample;
        seconds_elapsed <= elapsed;
        do
            @(posedge clk);
        while (in_stall);
        advance_daylight(sample, elapsed);
        transfers_in++;
    endtask

    // Drop valid and wait until every queued result has been taken
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic apply_settings(input logic [THR_W-1:0] up,
                                  input logic [THR_W-1:0] down,
                                  input logic [DELAY_W-1:0] delay);
        logic [CFG_W-THR_W-1:0] junk_hi;
        wait_idle();
        // threshold writes carry random upper bits, which must be dropped
        junk_hi = (CFG_W-THR_W)'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= REG_UP_THRESHOLD;
        cfg_data  <= {junk_hi, up};
        @(posedge clk);
        up_thr = up;
        junk_hi = (CFG_W-THR_W)'($urandom);
        cfg_index <= REG_DOWN_THRESHOLD;
        cfg_data  <= {junk_hi, down};
        @(posedge clk);
        down_thr = down;
        cfg_index <= REG_SLEEP_DELAY;
        cfg_data  <= delay;
        @(posedge clk);
        delay_cfg = delay;
        cfg_index <= REG_SPARE;
        cfg_data  <= CFG_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // Runs of light at one level with jitter, mixed with stray readings
    task automatic run_random_days(input int unsigned count);
        int unsigned left;
        int unsigned seg;
        int          level;
        int          lux;
        int unsigned roll;
        logic [ELAPSED_W-1:0] elapsed;
        left = count;
        while (left > 0)
        begin
            seg = $urandom_range(4, 60);
            if (seg > left)
                seg = left;
            case ($urandom_range(0, 3))
                0: level = $urandom_range(0, 120);
                1: level = $urandom_range(120, 320);
                2: level = $urandom_range(320, SAMPLE_MAX);
                default: level = -1;
            endcase
            idle_on = ($urandom_range(0, 4) != 0);
            repeat (seg)
            begin
                if (level < 0 || $urandom_range(0, 9) == 0)
                    lux = $urandom_range(0, SAMPLE_MAX);
                else
                begin
                    lux = level + $urandom_range(0, 80) - 40;
                    if (lux < 0)
                        lux = 0;
                    if (lux > SAMPLE_MAX)
                        lux = SAMPLE_MAX;
                end
                roll = $urandom_range(0, 9);
                if (roll < 5)
                    elapsed = '0;
                else if (roll < 8)
                    elapsed = 6'd1;
                else
                    elapsed = ELAPSED_W'($urandom_range(2, 63));
                send_item(SAMPLE_W'(lux), elapsed);
            end
            left -= seg;
        end
        idle_on = 1'b1;
    endtask

    // Reset settings: empty first second, window driven to full scale, then
    // multi-second steps with alternating bit patterns
    task automatic test_directed_extremes();
        send_item(SAMPLE_W'(SAMPLE_MAX), 6'd5);
        repeat (16) send_item(SAMPLE_W'(SAMPLE_MAX), 6'd1);
        send_item(10'h155, 6'd63);
        send_item(10'h2AA, 6'h2A);
        send_item('0, 6'h15);
        send_item('0, '0);
        send_item('0, 6'd1);
    endtask

    // Overfill two seconds: extra samples must not move the mean
    task automatic test_full_bin();
        send_item(SAMPLE_W'(SAMPLE_MAX), 6'd1);
        for (int k = 1; k < 260; k++)
            send_item(SAMPLE_W'((k < MAX_PER_SECOND) ? SAMPLE_MAX
                                                     : $urandom_range(0, SAMPLE_MAX)), '0);
        send_item('0, 6'd1);
        for (int k = 1; k < 260; k++)
            send_item(SAMPLE_W'((k < MAX_PER_SECOND) ? 0 : SAMPLE_MAX), '0);
        send_item(10'h2AA, 6'd1);
        send_item(10'h155, 6'd1);
    endtask

    // Always dark with a long delay: sleep must stay low until the dark time
    // passes the delay and then hold
    task automatic test_long_darkness();
        apply_settings(THR_W'(SAMPLE_MAX), THR_W'(SAMPLE_MAX), 16'h0FC0);
        idle_on = 1'b0;
        repeat (120) send_item(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), 6'd63);
        idle_on = 1'b1;
    endtask

    task automatic test_low_extremes();
        apply_settings('0, '0, '0);
        run_random_days(80);
    endtask

    // Up threshold below down threshold: both flags may be high together
    task automatic test_crossed_thresholds();
        apply_settings(10'd100, 10'd900, 16'd5);
        run_random_days(100);
    endtask

    task automatic test_random_days();
        logic [THR_W-1:0] up;
        logic [THR_W-1:0] down;
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
                apply_settings(UP_THRESHOLD_RST, DOWN_THRESHOLD_RST, SLEEP_DELAY_RST);
            else
            begin
                up   = THR_W'($urandom_range(60, 700));
                down = THR_W'($urandom_range(0, up));
                apply_settings(up, down, DELAY_W'($urandom_range(0, 48)));
            end
            run_random_days(50);
        end
    endtask

    // Random back-pressure on the result side
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (idle_on)
                stall_left = gap_len();
        end
    end

    // Check each result transfer against the oldest prediction; watch for hangs
    always @(posedge clk)
    begin
        daylight_result_t want;
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("daylight_sleep_wake_detector: mismatch");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                log_mismatch("result with no sample outstanding");
            else
            begin
                want = expected_results.pop_front();
                check_field("get_up", SUM_OUT_W'(want.get_up), SUM_OUT_W'(get_up));
                check_field("go_to_sleep", SUM_OUT_W'(want.go_to_sleep),
                            SUM_OUT_W'(go_to_sleep));
                check_field("window_sum", want.window_sum, window_sum);
                check_field("second_closed", SUM_OUT_W'(want.second_closed),
                            SUM_OUT_W'(second_closed));
                results_seen++;
                seconds_closed += second_closed;
                get_up_high    += get_up;
                sleep_high     += go_to_sleep;
            end
        end
    end

    initial
    begin
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= REG_UP_THRESHOLD;
        cfg_data        <= '0;
        in_valid        <= 1'b0;
        light_sample    <= '0;
        seconds_elapsed <= '0;
        out_stall       <= 1'b0;
        stall_left       = 0;
        idle_on          = 1'b1;
        quiet_cycles     = 0;
        mismatches       = 0;
        transfers_in     = 0;
        results_seen     = 0;
        seconds_closed   = 0;
        get_up_high      = 0;
        sleep_high       = 0;
        settings_applied = 0;
        reset_detector_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_full_bin();
        test_long_darkness();
        test_low_extremes();
        test_crossed_thresholds();
        test_random_days();

        // drain, then give any stray result time to show up
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            log_mismatch("predicted results never arrived");

        $display("Covered %0d samples, %0d seconds closed, %0d register settings.",
                 transfers_in, seconds_closed, settings_applied);
        $display("get_up high on %0d results, go_to_sleep high on %0d; %0d mismatches.",
                 get_up_high, sleep_high, mismatches);
        if (mismatches == 0)
            $display("daylight_sleep_wake_detector: match");
        else
            $display("daylight_sleep_wake_detector: mismatch");
        $finish;
    end

endmodule
